// File: rtl/c2s_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package c2s_pkg;

    // Field and pipeline geometry
    localparam int DATA_WIDTH    = 16;
    localparam int ITERATIONS    = 16;
    localparam int ATAN_LEN      = 24;
    localparam int CORDIC_STAGES = (ITERATIONS > ATAN_LEN) ? ATAN_LEN : ITERATIONS;
    localparam int IDX_W         = $clog2(ATAN_LEN);

    // Guard bits used to extend the radicand and the polar z operand
    localparam int GUARD         = 32 - DATA_WIDTH;
    localparam int SUM_W         = 2 * DATA_WIDTH;
    localparam int RAD_W         = SUM_W;
    localparam int ROOT_W        = DATA_WIDTH + GUARD;
    localparam int REM_W         = ROOT_W + 3;
    localparam int SQRT_STAGES   = ROOT_W;

    // CORDIC datapath
    localparam int WORK_SHIFT    = 28;
    localparam int CW            = 62;
    localparam int ANG_W         = 34;

    // Angle to output scale
    localparam int POL_SHIFT     = 31 - DATA_WIDTH;
    localparam int AZ_SHIFT      = 32 - DATA_WIDTH;

    typedef logic signed [CW-1:0]    t_work;
    typedef logic signed [ANG_W-1:0] t_angle;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt_lane;

    typedef struct packed {
        t_work  x;
        t_work  y;
        t_angle ang;
    } t_cordic_lane;

    localparam logic [SUM_W-1:0] ONE_SQ = SUM_W'(1) << (2 * (DATA_WIDTH - 2));

    localparam t_angle QUARTER_TURN = ANG_W'(1) << 30;
    localparam t_angle HALF_TURN    = ANG_W'(1) << 31;
    localparam t_angle POL_HALF     = ANG_W'(1) << (POL_SHIFT - 1);
    localparam t_angle AZ_HALF      = ANG_W'(1) << (AZ_SHIFT - 1);
    localparam t_angle POL_MAX      = t_angle'((ANG_W'(1) << DATA_WIDTH) - ANG_W'(1));

    // Arctangent of 2^-i in units of pi / 2^31
    function automatic t_angle atan_entry(input logic [IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return t_angle'({{(ANG_W - 32){1'b0}}, v});
    endfunction

endpackage

`default_nettype wire

// File: rtl/c2s_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One radix-4 digit of a restoring square root; retires one root bit per cycle.
module c2s_sqrt_cell (
    input  wire logic                i_clk,
    input  wire c2s_pkg::t_sqrt_lane i_lane,
    output c2s_pkg::t_sqrt_lane      o_lane
);

    logic [c2s_pkg::REM_W-1:0] rem_sh;
    logic [c2s_pkg::REM_W-1:0] trial;
    c2s_pkg::t_sqrt_lane       n_lane;
    c2s_pkg::t_sqrt_lane       r_lane;

    always_comb begin
        // bring down the next two radicand bits
        rem_sh     = {i_lane.rem[c2s_pkg::REM_W-3:0],
                      i_lane.rad[c2s_pkg::RAD_W-1 -: 2]};
        trial      = {1'b0, i_lane.root, 2'b01};
        n_lane.rad = {i_lane.rad[c2s_pkg::RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            n_lane.rem  = rem_sh - trial;
            n_lane.root = {i_lane.root[c2s_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_lane.rem  = rem_sh;
            n_lane.root = {i_lane.root[c2s_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_lane = r_lane;

endmodule

`default_nettype wire

// File: rtl/c2s_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One vectoring micro-rotation: drive y toward zero, accumulate the angle.
module c2s_cordic_cell (
    input  wire logic                        i_clk,
    input  wire logic [c2s_pkg::IDX_W-1:0]   i_index,
    input  wire c2s_pkg::t_cordic_lane       i_lane,
    output c2s_pkg::t_cordic_lane            o_lane
);

    c2s_pkg::t_work        dx;
    c2s_pkg::t_work        dy;
    c2s_pkg::t_angle       step;
    c2s_pkg::t_cordic_lane n_lane;
    c2s_pkg::t_cordic_lane r_lane;

    always_comb begin
        dx   = i_lane.y >>> i_index;
        dy   = i_lane.x >>> i_index;
        step = c2s_pkg::atan_entry(i_index);
        if (!i_lane.y[c2s_pkg::CW-1]) begin
            n_lane.x   = i_lane.x + dx;
            n_lane.y   = i_lane.y - dy;
            n_lane.ang = i_lane.ang + step;
        end else begin
            n_lane.x   = i_lane.x - dx;
            n_lane.y   = i_lane.y + dy;
            n_lane.ang = i_lane.ang - step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_lane = r_lane;

endmodule

`default_nettype wire

// File: rtl/cartesian_to_spherical.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// -------   ------------------   ------------------------------------------------
// request   start, busy (in/out) i_x_component, i_y_component, i_z_component
// result    o_valid strobe       o_radius, o_polar_angle, o_azimuth, o_status
//
// Fully pipelined: busy stays low, so a request is taken on every cycle that
// start is high. Each result strobes once its request has passed the squares,
// the sums, the 32-cell square-root chain, the CORDIC seeds, the 16-cell
// CORDIC chain and the output register.
// Synchronous active-low reset clears only the valid bits along the pipe.
// The receiver cannot stall; results are dropped onto the ports once.
module cartesian_to_spherical (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic signed [c2s_pkg::DATA_WIDTH-1:0] i_x_component,
    input  wire logic signed [c2s_pkg::DATA_WIDTH-1:0] i_y_component,
    input  wire logic signed [c2s_pkg::DATA_WIDTH-1:0] i_z_component,
    output logic                                       o_valid,
    output logic        [c2s_pkg::DATA_WIDTH-1:0]      o_radius,
    output logic        [c2s_pkg::DATA_WIDTH-1:0]      o_polar_angle,
    output logic signed [c2s_pkg::DATA_WIDTH-1:0]      o_azimuth,
    output logic                                       o_status
);

    localparam int D  = c2s_pkg::DATA_WIDTH;
    localparam int NS = c2s_pkg::SQRT_STAGES;
    localparam int NC = c2s_pkg::CORDIC_STAGES;

    // Sideband carried alongside the square-root chain
    typedef struct packed {
        logic                status;
        logic signed [D-1:0] x;
        logic signed [D-1:0] y;
        logic signed [D-1:0] z;
    } t_sq_side;

    // Sideband carried alongside the CORDIC chain; the exact-axis cases
    // bypass the micro-rotations with a fixed angle
    typedef struct packed {
        logic                    status;
        logic [D-1:0]            radius;
        logic                    pol_spec;
        c2s_pkg::t_angle         pol_val;
        logic                    az_spec;
        c2s_pkg::t_angle         az_val;
    } t_cd_side;

    // Rotate left half plane vectors by a quarter turn into the right half
    function automatic c2s_pkg::t_cordic_lane fold_in(input c2s_pkg::t_work x,
                                                      input c2s_pkg::t_work y);
        c2s_pkg::t_cordic_lane lane;
        lane.x   = x;
        lane.y   = y;
        lane.ang = '0;
        if (x[c2s_pkg::CW-1]) begin
            if (!y[c2s_pkg::CW-1]) begin
                lane.x   = y;
                lane.y   = -x;
                lane.ang = c2s_pkg::QUARTER_TURN;
            end else begin
                lane.x   = -y;
                lane.y   = x;
                lane.ang = -c2s_pkg::QUARTER_TURN;
            end
        end
        return lane;
    endfunction

    // ---------------------------------------------------------------
    // Stage A: squares of the three components
    // ---------------------------------------------------------------
    logic signed [c2s_pkg::SUM_W-1:0] sq_x;
    logic signed [c2s_pkg::SUM_W-1:0] sq_y;
    logic signed [c2s_pkg::SUM_W-1:0] sq_z;
    logic                             accept;

    logic                             r_a_vld;
    logic        [c2s_pkg::SUM_W-1:0] r_a_sqx;
    logic        [c2s_pkg::SUM_W-1:0] r_a_sqy;
    logic        [c2s_pkg::SUM_W-1:0] r_a_sqz;
    t_sq_side                         r_a_side;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign sq_x = i_x_component * i_x_component;
    assign sq_y = i_y_component * i_y_component;
    assign sq_z = i_z_component * i_z_component;

    // ---------------------------------------------------------------
    // Stage B: sums, physical-range check, seed the root lanes
    // ---------------------------------------------------------------
    logic [c2s_pkg::SUM_W-1:0] sum_xy;
    logic [c2s_pkg::SUM_W-1:0] sum_all;
    t_sq_side                  n_b_side;
    c2s_pkg::t_sqrt_lane       n_b_rad;
    c2s_pkg::t_sqrt_lane       n_b_rho;
    c2s_pkg::t_sqrt_lane       r_b_rad;
    c2s_pkg::t_sqrt_lane       r_b_rho;

    always_comb begin
        sum_xy          = r_a_sqx + r_a_sqy;
        sum_all         = sum_xy + r_a_sqz;
        n_b_side        = r_a_side;
        n_b_side.status = (sum_all > c2s_pkg::ONE_SQ);
        // both roots are taken of the value extended by 2*GUARD zero bits
        n_b_rad.rad     = sum_all;
        n_b_rad.rem     = '0;
        n_b_rad.root    = '0;
        n_b_rho.rad     = sum_xy;
        n_b_rho.rem     = '0;
        n_b_rho.root    = '0;
    end

    // ---------------------------------------------------------------
    // Square-root chain: one root bit per cell, radius and rho lanes
    // ---------------------------------------------------------------
    c2s_pkg::t_sqrt_lane sq_rad [0:NS];
    c2s_pkg::t_sqrt_lane sq_rho [0:NS];
    t_sq_side            r_sq_side [0:NS];
    logic                r_sq_vld  [0:NS];

    assign sq_rad[0] = r_b_rad;
    assign sq_rho[0] = r_b_rho;

    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        c2s_sqrt_cell u_rad (
            .i_clk  (i_clk),
            .i_lane (sq_rad[k]),
            .o_lane (sq_rad[k+1])
        );
        c2s_sqrt_cell u_rho (
            .i_clk  (i_clk),
            .i_lane (sq_rho[k]),
            .o_lane (sq_rho[k+1])
        );
    end

    // ---------------------------------------------------------------
    // Prep stage: round the radius, scale and fold the CORDIC seeds,
    // pick out the exact-axis angles
    // ---------------------------------------------------------------
    logic [c2s_pkg::ROOT_W-1:0] root_r;
    logic [c2s_pkg::ROOT_W-1:0] rho;
    logic [D:0]                 rad_sum;
    t_sq_side                   sq_end;
    c2s_pkg::t_work             pol_x;
    c2s_pkg::t_work             pol_y;
    c2s_pkg::t_work             az_x;
    c2s_pkg::t_work             az_y;
    t_cd_side                   n_p_side;
    c2s_pkg::t_cordic_lane      n_p_pol;
    c2s_pkg::t_cordic_lane      n_p_az;
    c2s_pkg::t_cordic_lane      r_p_pol;
    c2s_pkg::t_cordic_lane      r_p_az;

    always_comb begin
        sq_end  = r_sq_side[NS];
        root_r  = sq_rad[NS].root;
        rho     = sq_rho[NS].root;
        // round half up on the first guard bit
        rad_sum = {1'b0, root_r[c2s_pkg::ROOT_W-1:c2s_pkg::GUARD]}
                + (D+1)'(root_r[c2s_pkg::GUARD-1]);

        n_p_side.status = sq_end.status;
        n_p_side.radius = rad_sum[D] ? {D{1'b1}} : rad_sum[D-1:0];

        // polar: atan2(rho, z scaled by 2^GUARD)
        pol_x = {{(c2s_pkg::CW-D){sq_end.z[D-1]}}, sq_end.z}
                <<< (c2s_pkg::GUARD + c2s_pkg::WORK_SHIFT);
        pol_y = {{(c2s_pkg::CW-c2s_pkg::ROOT_W){1'b0}}, rho} << c2s_pkg::WORK_SHIFT;
        // azimuth: atan2(y, x)
        az_x  = {{(c2s_pkg::CW-D){sq_end.x[D-1]}}, sq_end.x} <<< c2s_pkg::WORK_SHIFT;
        az_y  = {{(c2s_pkg::CW-D){sq_end.y[D-1]}}, sq_end.y} <<< c2s_pkg::WORK_SHIFT;

        n_p_pol = fold_in(pol_x, pol_y);
        n_p_az  = fold_in(az_x, az_y);

        // on the z axis (and at the origin) the polar angle is 0 or pi; in the xy plane it is pi/2
        n_p_side.pol_spec = 1'b0;
        n_p_side.pol_val  = '0;
        if (rho == '0) begin
            n_p_side.pol_spec = 1'b1;
            n_p_side.pol_val  = sq_end.z[D-1] ? c2s_pkg::HALF_TURN : '0;
        end else if (sq_end.z == '0) begin
            n_p_side.pol_spec = 1'b1;
            n_p_side.pol_val  = c2s_pkg::QUARTER_TURN;
        end

        // on the x or y axis the azimuth is an exact quarter-turn multiple
        n_p_side.az_spec = 1'b0;
        n_p_side.az_val  = '0;
        if (sq_end.y == '0) begin
            n_p_side.az_spec = 1'b1;
            n_p_side.az_val  = sq_end.x[D-1] ? c2s_pkg::HALF_TURN : '0;
        end else if (sq_end.x == '0) begin
            n_p_side.az_spec = 1'b1;
            n_p_side.az_val  = sq_end.y[D-1] ? -c2s_pkg::QUARTER_TURN
                                             : c2s_pkg::QUARTER_TURN;
        end
    end

    // ---------------------------------------------------------------
    // CORDIC chain: one micro-rotation per cell, polar and azimuth lanes
    // ---------------------------------------------------------------
    c2s_pkg::t_cordic_lane cd_pol [0:NC];
    c2s_pkg::t_cordic_lane cd_az  [0:NC];
    t_cd_side              r_cd_side [0:NC];
    logic                  r_cd_vld  [0:NC];

    assign cd_pol[0] = r_p_pol;
    assign cd_az[0]  = r_p_az;

    for (genvar j = 0; j < NC; j++) begin : g_cordic
        c2s_cordic_cell u_pol (
            .i_clk   (i_clk),
            .i_index (c2s_pkg::IDX_W'(j)),
            .i_lane  (cd_pol[j]),
            .o_lane  (cd_pol[j+1])
        );
        c2s_cordic_cell u_az (
            .i_clk   (i_clk),
            .i_index (c2s_pkg::IDX_W'(j)),
            .i_lane  (cd_az[j]),
            .o_lane  (cd_az[j+1])
        );
    end

    // ---------------------------------------------------------------
    // Output stage: take bypass angles, round to output scale, clamp
    // ---------------------------------------------------------------
    t_cd_side        cd_end;
    c2s_pkg::t_angle pol_ang;
    c2s_pkg::t_angle az_ang;
    c2s_pkg::t_angle pol_sh;
    c2s_pkg::t_angle az_sh;
    logic [D-1:0]    n_out_polar;
    logic [D-1:0]    n_out_azim;

    logic            r_out_vld;
    logic [D-1:0]    r_out_radius;
    logic [D-1:0]    r_out_polar;
    logic [D-1:0]    r_out_azim;
    logic            r_out_status;

    always_comb begin
        cd_end  = r_cd_side[NC];
        pol_ang = cd_end.pol_spec ? cd_end.pol_val : cd_pol[NC].ang;
        az_ang  = cd_end.az_spec  ? cd_end.az_val  : cd_az[NC].ang;
        pol_sh  = (pol_ang + c2s_pkg::POL_HALF) >>> c2s_pkg::POL_SHIFT;
        az_sh   = (az_ang + c2s_pkg::AZ_HALF) >>> c2s_pkg::AZ_SHIFT;

        if (pol_sh[c2s_pkg::ANG_W-1]) begin
            n_out_polar = '0;
        end else if (pol_sh > c2s_pkg::POL_MAX) begin
            n_out_polar = {D{1'b1}};
        end else begin
            n_out_polar = pol_sh[D-1:0];
        end
        // pi wraps to the negative end of the signed field
        n_out_azim = az_sh[D-1:0];

        // out-of-range vectors report the radius only
        if (cd_end.status) begin
            n_out_polar = '0;
            n_out_azim  = '0;
        end
    end

    // ---------------------------------------------------------------
    // Valid bits: cleared by reset, advance every cycle
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k <= NS; k++) begin
                r_sq_vld[k] <= 1'b0;
            end
            for (int j = 0; j <= NC; j++) begin
                r_cd_vld[j] <= 1'b0;
            end
        end else begin
            r_a_vld     <= accept;
            r_sq_vld[0] <= r_a_vld;
            for (int k = 1; k <= NS; k++) begin
                r_sq_vld[k] <= r_sq_vld[k-1];
            end
            r_cd_vld[0] <= r_sq_vld[NS];
            for (int j = 1; j <= NC; j++) begin
                r_cd_vld[j] <= r_cd_vld[j-1];
            end
            r_out_vld <= r_cd_vld[NC];
        end
    end

    // ---------------------------------------------------------------
    // Payload registers: no reset, advance every cycle
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_a_sqx         <= $unsigned(sq_x);
        r_a_sqy         <= $unsigned(sq_y);
        r_a_sqz         <= $unsigned(sq_z);
        r_a_side.status <= 1'b0;
        r_a_side.x      <= i_x_component;
        r_a_side.y      <= i_y_component;
        r_a_side.z      <= i_z_component;

        r_b_rad         <= n_b_rad;
        r_b_rho         <= n_b_rho;
        r_sq_side[0]    <= n_b_side;
        for (int k = 1; k <= NS; k++) begin
            r_sq_side[k] <= r_sq_side[k-1];
        end

        r_p_pol         <= n_p_pol;
        r_p_az          <= n_p_az;
        r_cd_side[0]    <= n_p_side;
        for (int j = 1; j <= NC; j++) begin
            r_cd_side[j] <= r_cd_side[j-1];
        end

        r_out_radius    <= cd_end.radius;
        r_out_polar     <= n_out_polar;
        r_out_azim      <= n_out_azim;
        r_out_status    <= cd_end.status;
    end

    assign o_valid       = r_out_vld;
    assign o_radius      = r_out_radius;
    assign o_polar_angle = r_out_polar;
    assign o_azimuth     = $signed(r_out_azim);
    assign o_status      = r_out_status;

endmodule

`default_nettype wire

// File: verif/tb_cartesian_to_spherical.sv
`timescale 1ns / 1ps

// Self-checking bench for the Cartesian to spherical converter.
//
// An initial block queues the requests: a directed set first (zero vector,
// unit axes, the poles, the negative x axis, the unit-sphere boundary, the
// extreme codes, every quadrant), then randomized vectors weighted toward
// the inside of the unit ball, where the angles are computed at all.
// A clocked driver issues one request at a time with random gaps and
// occasional back-to-back bursts. For each taken request it predicts the
// result with a CORDIC model of its own and queues it. A clocked monitor
// compares every strobed result, field by field, against the oldest
// prediction.
module tb_cartesian_to_spherical;

    localparam int DW = c2s_pkg::DATA_WIDTH;
    localparam int ROT_STEPS = c2s_pkg::CORDIC_STAGES;
    // Extra fraction bits given to hypot(x,y) and z ahead of the polar CORDIC
    localparam int HEADROOM = 32 - DW;
    localparam longint HALF_PI_UNITS = 64'sd1 <<< 30;
    localparam longint PI_UNITS = 64'sd1 <<< 31;
    localparam longint FIELD_MAX = (64'sd1 <<< DW) - 1;
    localparam longint unsigned UNIT_LEN_SQ = 64'd1 << (2 * (DW - 2));
    localparam int UNIT_CODE = 1 << (DW - 2);
    localparam int PIPE_LATENCY = 52;
    localparam int DRAIN_CYCLES = PIPE_LATENCY + 8;
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_REQUESTS = 1200;

    // arctan(2^-i) in units of pi / 2^31, rounded to nearest
    localparam longint ARCTAN_STEP [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
        64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    typedef struct {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
    } t_cart_vec;

    typedef struct {
        logic        [DW-1:0] radius;
        logic        [DW-1:0] polar;
        logic signed [DW-1:0] azimuth;
        logic                 status;
    } t_sph_coord;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic signed [DW-1:0] i_x_component = '0;
    logic signed [DW-1:0] i_y_component = '0;
    logic signed [DW-1:0] i_z_component = '0;
    logic                 o_valid;
    logic        [DW-1:0] o_radius;
    logic        [DW-1:0] o_polar_angle;
    logic signed [DW-1:0] o_azimuth;
    logic                 o_status;

    t_cart_vec  vector_q[$];      // requests not yet issued
    t_sph_coord coord_q[$];       // predicted results, oldest first
    t_cart_vec  vec_on_bus;
    int         gap_left = 0;
    bit         burst_mode = 1'b0;
    int         stall_cycles = 0;
    int         error_count = 0;

    cartesian_to_spherical dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_x_component (i_x_component),
        .i_y_component (i_y_component),
        .i_z_component (i_z_component),
        .o_valid       (o_valid),
        .o_radius      (o_radius),
        .o_polar_angle (o_polar_angle),
        .o_azimuth     (o_azimuth),
        .o_status      (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bit-serial integer square root, floor
    function automatic longint unsigned floor_sqrt(input longint unsigned radicand);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > radicand)
            probe >>= 2;
        while (probe != 0) begin
            if (radicand >= root + probe) begin
                radicand -= root + probe;
                root = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    // Vectoring CORDIC: atan2(yy, xx) in units of pi / 2^31
    function automatic longint cordic_atan2(input longint yy, input longint xx);
        longint cx, cy, acc, tmp, dx, dy;
        int     i;
        // Exact axes bypass the rotations
        if (yy == 0)
            return (xx < 0) ? PI_UNITS : 64'sd0;
        if (xx == 0)
            return (yy > 0) ? HALF_PI_UNITS : -HALF_PI_UNITS;
        cx = xx <<< 28;
        cy = yy <<< 28;
        acc = 0;
        // Fold the left half plane in by a quarter turn
        if (cx < 0) begin
            tmp = cx;
            if (cy >= 0) begin
                cx = cy;
                cy = -tmp;
                acc = HALF_PI_UNITS;
            end else begin
                cx = -cy;
                cy = tmp;
                acc = -HALF_PI_UNITS;
            end
        end
        for (i = 0; i < ROT_STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx += dx;
                cy -= dy;
                acc += ARCTAN_STEP[i];
            end else begin
                cx -= dx;
                cy += dy;
                acc -= ARCTAN_STEP[i];
            end
        end
        return acc;
    endfunction

    // Round an angle in pi / 2^31 to pi / 2^frac_bits: add half an LSB, shift
    function automatic longint angle_to_field(input longint ang, input int frac_bits);
        int sh;
        sh = 31 - frac_bits;
        return (ang + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic t_sph_coord spherical_of(input t_cart_vec v);
        longint          sx, sy, sz, rho, pol, az;
        longint unsigned sq_xy, sq_len, root;
        t_sph_coord      res;
        sx = v.x;
        sy = v.y;
        sz = v.z;
        sq_xy = sx * sx + sy * sy;
        sq_len = sq_xy + sz * sz;
        // Round the length to nearest, ties up
        root = floor_sqrt(sq_len);
        if (sq_len - root * root > root)
            root++;
        res.radius = (root > FIELD_MAX) ? FIELD_MAX[DW-1:0] : root[DW-1:0];
        res.status = (sq_len > UNIT_LEN_SQ);
        res.polar = '0;
        res.azimuth = '0;
        // Non-physical vectors keep both angles at zero
        if (!res.status) begin
            rho = floor_sqrt(sq_xy << (2 * HEADROOM));
            pol = angle_to_field(cordic_atan2(rho, sz <<< HEADROOM), DW);
            az = angle_to_field(cordic_atan2(sy, sx), DW - 1);
            // The south pole gives a full pi; saturate it
            if (pol < 0)
                pol = 0;
            if (pol > FIELD_MAX)
                pol = FIELD_MAX;
            res.polar = pol[DW-1:0];
            // pi on the negative x axis wraps to the most negative code
            res.azimuth = az[DW-1:0];
        end
        return res;
    endfunction

    task automatic queue_vector(input int x, input int y, input int z);
        t_cart_vec v;
        v.x = DW'(x);
        v.y = DW'(y);
        v.z = DW'(z);
        vector_q.push_back(v);
    endtask

    // Driver: issue queued requests, hold each until it is taken, then idle
    // for a random gap (none at all while a burst is running).
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left = 0;
        end else if (!(start && busy)) begin
            if (start) begin
                // The request on the bus was taken at this edge
                coord_q.push_back(spherical_of(vec_on_bus));
                if ($urandom_range(0, 39) == 0)
                    burst_mode = !burst_mode;
                gap_left = burst_mode ? 0 : $urandom_range(0, 11);
            end
            if (gap_left != 0 || vector_q.size() == 0) begin
                if (gap_left != 0)
                    gap_left--;
                start <= 1'b0;
            end else begin
                vec_on_bus = vector_q.pop_front();
                i_x_component <= vec_on_bus.x;
                i_y_component <= vec_on_bus.y;
                i_z_component <= vec_on_bus.z;
                start <= 1'b1;
            end
        end
    end

    // Monitor: every strobe must match the oldest prediction
    always @(posedge i_clk) begin
        t_sph_coord want;
        if (i_rst_n && o_valid) begin
            if (coord_q.size() == 0) begin
                $error("result strobed with no request outstanding");
                error_count++;
            end else begin
                want = coord_q.pop_front();
                if (o_radius !== want.radius) begin
                    $error("radius: expected %0d, got %0d", want.radius, o_radius);
                    error_count++;
                end
                if (o_polar_angle !== want.polar) begin
                    $error("polar_angle: expected %0d, got %0d", want.polar, o_polar_angle);
                    error_count++;
                end
                if (o_azimuth !== want.azimuth) begin
                    $error("azimuth: expected %0d, got %0d", want.azimuth, o_azimuth);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither a request nor a result moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        int rx, ry, rz, pick, n;

        // Directed requests
        queue_vector(0, 0, 0);                     // zero vector
        queue_vector(UNIT_CODE, 0, 0);             // exactly on the unit sphere
        queue_vector(-UNIT_CODE, 0, 0);            // negative x axis, azimuth wraps
        queue_vector(0, UNIT_CODE, 0);
        queue_vector(0, -UNIT_CODE, 0);
        queue_vector(0, 0, UNIT_CODE);             // north pole
        queue_vector(0, 0, -UNIT_CODE);            // south pole, polar saturates
        queue_vector(-9000, 0, 5000);              // negative x axis off the plane
        queue_vector(UNIT_CODE + 1, 0, 0);         // just outside the unit sphere
        queue_vector(32767, 32767, 32767);
        queue_vector(-32768, -32768, -32768);
        queue_vector(-32768, 0, 0);
        queue_vector(0, 32767, 0);
        queue_vector(1, 0, 0);
        queue_vector(0, 0, -1);
        queue_vector(-1, -1, -1);
        queue_vector(9459, 9459, 9459);            // diagonal, inside
        queue_vector(9460, 9460, 9460);            // diagonal, outside
        queue_vector(-7000, 3000, -9000);          // second quadrant
        queue_vector(-7000, -3000, 9000);          // third quadrant
        queue_vector(7000, -3000, 0);              // fourth quadrant, equator
        queue_vector(0, -5000, -5000);             // x = 0 only
        queue_vector(1, -1, 0);
        queue_vector(11585, 11585, 0);

        // Random requests, mostly inside the unit ball
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                // Rejection-sample the unit ball
                do begin
                    rx = int'($urandom_range(0, 2 * UNIT_CODE)) - UNIT_CODE;
                    ry = int'($urandom_range(0, 2 * UNIT_CODE)) - UNIT_CODE;
                    rz = int'($urandom_range(0, 2 * UNIT_CODE)) - UNIT_CODE;
                end while (rx * rx + ry * ry + rz * rz > UNIT_CODE * UNIT_CODE);
                if (pick < 12) begin
                    // Drop one or two components onto an axis or a plane
                    case ($urandom_range(0, 5))
                        0: rx = 0;
                        1: ry = 0;
                        2: rz = 0;
                        3: begin rx = 0; ry = 0; end
                        4: begin rx = 0; rz = 0; end
                        default: begin ry = 0; rz = 0; end
                    endcase
                end else if (pick < 25) begin
                    // Tiny vectors exercise the fine CORDIC steps
                    rx = rx >>> 8;
                    ry = ry >>> 8;
                    rz = rz >>> 8;
                end
            end else if (pick < 86) begin
                // Straddle the unit-sphere boundary
                rx = UNIT_CODE - int'($urandom_range(0, 3));
                if ($urandom_range(0, 1))
                    rx = -rx;
                ry = int'($urandom_range(0, 400)) - 200;
                rz = int'($urandom_range(0, 400)) - 200;
            end else begin
                // Full code range, mostly non-physical
                rx = int'($urandom_range(0, 65535)) - 32768;
                ry = int'($urandom_range(0, 65535)) - 32768;
                rz = int'($urandom_range(0, 65535)) - 32768;
            end
            queue_vector(rx, ry, rz);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample on the falling edge, clear of the clocked processes
        while ((vector_q.size() != 0 || start || coord_q.size() != 0) &&
               stall_cycles < STALL_LIMIT)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        if (stall_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
        end else begin
            if (coord_q.size() != 0) begin
                $error("%0d predicted results never arrived", coord_q.size());
                error_count++;
            end
            if (error_count == 0)
                $display("*** PASSED ***");
            else
                $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
